// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the burn-in counter reader.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BCR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bcr_pkg.sv =====
// Package with shared constants, register codes and types of the burn-in counter reader.
`timescale 1ns / 1ps

package bcr_pkg;

    localparam int COUNTER_BITS   = 32;
    localparam int INDEX_BITS     = 24;
    localparam int LUMA_BITS      = 8;
    localparam int START_BITS     = 11;
    localparam int CELL_BITS      = 8;
    localparam int FWIDTH_BITS    = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;
    localparam int TAKEN_BITS     = $clog2(COUNTER_BITS + 1);
    localparam int HALF_BITS      = CELL_BITS - 1;
    localparam int BASE_SUM_BITS  = START_BITS + 1;
    localparam int BASE_BITS      = BASE_SUM_BITS + FWIDTH_BITS;
    localparam int OFF_BITS       = TAKEN_BITS + 1 + HALF_BITS;
    localparam int TARGET_BITS    = BASE_BITS;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = 2;
    localparam int QCNT_BITS      = 3;
    localparam int SYNC_BITS      = 2;

    localparam logic [LUMA_BITS-1:0]    LUMA_THRESHOLD = 8'h80;
    localparam logic [INDEX_BITS-1:0]   INDEX_CEILING  = {INDEX_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0] WORD_ONES      = {COUNTER_BITS{1'b1}};
    localparam logic [SYNC_BITS-1:0]    SYNC_START     = 2'd2;
    localparam logic [SYNC_BITS-1:0]    SYNC_LOAD      = 2'd1;
    localparam logic [SYNC_BITS-1:0]    SYNC_DONE      = 2'd0;

    localparam logic [CFG_INDEX_BITS-1:0] REG_START_LINE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BIT_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BIT_HEIGHT  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 2'd3;

    localparam logic [START_BITS-1:0]  RST_START_LINE  = 11'd200;
    localparam logic [CELL_BITS-1:0]   RST_BIT_WIDTH   = 8'd30;
    localparam logic [CELL_BITS-1:0]   RST_BIT_HEIGHT  = 8'd30;
    localparam logic [FWIDTH_BITS-1:0] RST_FRAME_WIDTH = 13'd1920;

    typedef struct packed {
        logic [START_BITS-1:0]  start_line;
        logic [CELL_BITS-1:0]   bit_width;
        logic [CELL_BITS-1:0]   bit_height;
        logic [FWIDTH_BITS-1:0] frame_width;
    } cfg_t;

    typedef struct packed {
        logic                    last;
        logic [COUNTER_BITS-1:0] set_mask;
    } qent_t;

endpackage

// ===== hw/rtl/bcr_front.sv =====
// Front end: pixel index tracking, sample position compare and bit mask generation.
`timescale 1ns / 1ps

module bcr_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bcr_pkg::cfg_t                 cfg,
    input  logic                          cfg_wr,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bcr_pkg::LUMA_BITS-1:0] luma,
    input  logic                          frame_end,
    input  logic                          q_full,
    output logic                          push,
    output bcr_pkg::qent_t                push_data
);

    logic [bcr_pkg::INDEX_BITS-1:0]    pixel_index_reg, pixel_index_next;
    logic [bcr_pkg::TAKEN_BITS-1:0]    bits_taken_reg, bits_taken_next;
    logic [bcr_pkg::TARGET_BITS-1:0]   target_reg, target_next;
    logic [bcr_pkg::BASE_BITS-1:0]     base_prod_reg, base_prod_next;
    logic [bcr_pkg::OFF_BITS-1:0]      off_prod_reg, off_prod_next;
    logic [bcr_pkg::SYNC_BITS-1:0]     sync_reg, sync_next;

    logic [bcr_pkg::HALF_BITS-1:0]     half;
    logic [bcr_pkg::BASE_SUM_BITS-1:0] base_sum;
    logic                              accept;
    logic                              hit;
    logic                              take_all;
    logic [bcr_pkg::TAKEN_BITS-1:0]    take_cnt;
    logic [bcr_pkg::TAKEN_BITS-1:0]    end_pos;
    logic [bcr_pkg::COUNTER_BITS-1:0]  span_mask;

    assign half     = cfg.bit_width[bcr_pkg::CELL_BITS-1:1];
    assign base_sum = bcr_pkg::BASE_SUM_BITS'(cfg.start_line)
                    + bcr_pkg::BASE_SUM_BITS'(cfg.bit_height[bcr_pkg::CELL_BITS-1:1]);

    assign base_prod_next = bcr_pkg::BASE_BITS'(base_sum) * bcr_pkg::BASE_BITS'(cfg.frame_width);
    assign off_prod_next  = bcr_pkg::OFF_BITS'({bits_taken_reg, 1'b1})
                          * bcr_pkg::OFF_BITS'(half);

    assign in_ready = !q_full && (sync_reg == bcr_pkg::SYNC_DONE);
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    assign hit = (pixel_index_reg != bcr_pkg::INDEX_CEILING)
              && (bits_taken_reg < bcr_pkg::TAKEN_BITS'(bcr_pkg::COUNTER_BITS))
              && (bcr_pkg::TARGET_BITS'(pixel_index_reg) == target_reg);

    // zero half cell: every remaining bit samples the same pixel
    assign take_all  = (half == '0);
    assign take_cnt  = take_all ? bcr_pkg::TAKEN_BITS'(bcr_pkg::COUNTER_BITS) - bits_taken_reg
                                : bcr_pkg::TAKEN_BITS'(1);
    assign end_pos   = bits_taken_reg + take_cnt;
    assign span_mask = (bcr_pkg::WORD_ONES >> bits_taken_reg) & ~(bcr_pkg::WORD_ONES >> end_pos);

    always_comb
    begin
        push_data.last     = frame_end;
        push_data.set_mask = (hit && (luma > bcr_pkg::LUMA_THRESHOLD)) ? span_mask : '0;
    end

    always_comb
    begin
        pixel_index_next = pixel_index_reg;
        bits_taken_next  = bits_taken_reg;
        target_next      = target_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                pixel_index_next = '0;
                bits_taken_next  = '0;
                target_next      = base_prod_reg + bcr_pkg::TARGET_BITS'(half);
            end
            else
            begin
                if (pixel_index_reg != bcr_pkg::INDEX_CEILING)
                begin
                    pixel_index_next = pixel_index_reg + 1'b1;
                end
                if (hit)
                begin
                    bits_taken_next = end_pos;
                    if (!take_all)
                    begin
                        target_next = target_reg + bcr_pkg::TARGET_BITS'({half, 1'b0});
                    end
                end
            end
        end
        else if (sync_reg == bcr_pkg::SYNC_LOAD)
        begin
            target_next = base_prod_reg + bcr_pkg::TARGET_BITS'(off_prod_reg);
        end
    end

    always_comb
    begin
        if (cfg_wr)
        begin
            sync_next = bcr_pkg::SYNC_START;
        end
        else if (sync_reg != bcr_pkg::SYNC_DONE)
        begin
            sync_next = sync_reg - 1'b1;
        end
        else
        begin
            sync_next = sync_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_index_reg <= '0;
            bits_taken_reg  <= '0;
            target_reg      <= '0;
            sync_reg        <= bcr_pkg::SYNC_START;
        end
        else
        begin
            pixel_index_reg <= pixel_index_next;
            bits_taken_reg  <= bits_taken_next;
            target_reg      <= target_next;
            sync_reg        <= sync_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_prod_reg <= base_prod_next;
        off_prod_reg  <= off_prod_next;
    end

endmodule

// ===== hw/rtl/bcr_queue.sv =====
// Short FIFO carrying classified pixel requests from the front end to the back end.
`timescale 1ns / 1ps

module bcr_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bcr_pkg::qent_t push_data,
    input  logic           pop,
    output bcr_pkg::qent_t head,
    output logic           not_empty,
    output logic           full
);

    bcr_pkg::qent_t                 mem_reg [bcr_pkg::QUEUE_DEPTH];
    logic [bcr_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bcr_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bcr_pkg::QCNT_BITS-1:0]  count_reg, count_next;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == bcr_pkg::QCNT_BITS'(bcr_pkg::QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/bcr_back.sv =====
// Back end: word assembly, continuity check, counters and the result register.
`timescale 1ns / 1ps

module bcr_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  bcr_pkg::qent_t                   head,
    input  logic                             q_not_empty,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bcr_pkg::COUNTER_BITS-1:0] counter_value,
    output logic                             discontinuity,
    output logic                             resumed,
    output logic                             in_error,
    output logic [31:0]                      error_total,
    output logic [31:0]                      frames_seen
);

    logic [bcr_pkg::COUNTER_BITS-1:0] word_reg, word_next;
    logic [bcr_pkg::COUNTER_BITS-1:0] prev_reg, prev_next;
    logic [31:0]                      err_cnt_reg, err_cnt_next;
    logic [31:0]                      frames_reg, frames_next;
    logic                             mode_reg, mode_next;
    logic                             out_valid_reg, out_valid_next;

    logic [bcr_pkg::COUNTER_BITS-1:0] value_reg;
    logic                             jump_reg;
    logic                             resumed_reg;

    logic [bcr_pkg::COUNTER_BITS-1:0] word_upd;
    logic [bcr_pkg::COUNTER_BITS:0]   expected;
    logic                             jump;
    logic                             finish;

    assign pop      = q_not_empty && (!head.last || !out_valid_reg || out_ready);
    assign finish   = pop && head.last;
    assign word_upd = word_reg | head.set_mask;
    assign expected = {1'b0, prev_reg} + 1'b1;
    // wrap of the previous word counts as a break
    assign jump     = (prev_reg != '0) && (expected != {1'b0, word_upd});

    always_comb
    begin
        word_next      = word_reg;
        prev_next      = prev_reg;
        err_cnt_next   = err_cnt_reg;
        frames_next    = frames_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop)
        begin
            word_next = word_upd;
        end
        if (finish)
        begin
            word_next      = '0;
            prev_next      = word_upd;
            frames_next    = frames_reg + 1'b1;
            mode_next      = jump;
            out_valid_next = 1'b1;
            if (jump && (err_cnt_reg != 32'hFFFF_FFFF))
            begin
                err_cnt_next = err_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg      <= '0;
            prev_reg      <= '0;
            err_cnt_reg   <= '0;
            frames_reg    <= '0;
            mode_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            word_reg      <= word_next;
            prev_reg      <= prev_next;
            err_cnt_reg   <= err_cnt_next;
            frames_reg    <= frames_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            value_reg   <= word_upd;
            jump_reg    <= jump;
            resumed_reg <= !jump && mode_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign counter_value = value_reg;
    assign discontinuity = jump_reg;
    assign resumed       = resumed_reg;
    assign in_error      = mode_reg;
    assign error_total   = err_cnt_reg;
    assign frames_seen   = frames_reg;

endmodule

// ===== hw/rtl/burnin_counter_reader.sv =====
// Top level of the burn-in counter reader: register file, front end, queue and back end.
//
// Usage: luma pixels of each frame enter in raster order on the in_valid/in_ready
// channel, with frame_end high on the last pixel. Each accepted request with
// frame_end high yields one result request on out_valid/out_ready carrying the
// decoded word, the continuity flags and the running counts; other pixels yield none.
// Registers are written on cfg_valid/cfg_ready (cfg_ready is always high), by index;
// the user must write only while the block is idle; the block does not enforce it.
// Throughput: one pixel per cycle while in_ready is high. After reset and after every
// register write the input channel holds in_ready low while the sample row offset
// multipliers settle and the next sample position is reloaded.
// The last pixel of a frame is queued, and the result is registered when it is popped.
// A stalled receiver holds the result register; pixels keep flowing through the
// four-entry queue until the next frame end reaches its head, and in_ready drops
// once four requests wait there.
// Reset clears all counts and the word history and sets error mode.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module burnin_counter_reader
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bcr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bcr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bcr_pkg::LUMA_BITS-1:0]       luma,
    input  logic                                frame_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bcr_pkg::COUNTER_BITS-1:0]    counter_value,
    output logic                                discontinuity,
    output logic                                resumed,
    output logic                                in_error,
    output logic [31:0]                         error_total,
    output logic [31:0]                         frames_seen
);

    bcr_pkg::cfg_t  cfg_reg, cfg_next;
    logic           cfg_wr;
    logic           q_full;
    logic           q_not_empty;
    logic           push;
    logic           pop;
    bcr_pkg::qent_t push_data;
    bcr_pkg::qent_t head;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                bcr_pkg::REG_START_LINE:
                    cfg_next.start_line = cfg_data[bcr_pkg::START_BITS-1:0];
                bcr_pkg::REG_BIT_WIDTH:
                    cfg_next.bit_width = cfg_data[bcr_pkg::CELL_BITS-1:0];
                bcr_pkg::REG_BIT_HEIGHT:
                    cfg_next.bit_height = cfg_data[bcr_pkg::CELL_BITS-1:0];
                bcr_pkg::REG_FRAME_WIDTH:
                    cfg_next.frame_width = cfg_data[bcr_pkg::FWIDTH_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_line  <= bcr_pkg::RST_START_LINE;
            cfg_reg.bit_width   <= bcr_pkg::RST_BIT_WIDTH;
            cfg_reg.bit_height  <= bcr_pkg::RST_BIT_HEIGHT;
            cfg_reg.frame_width <= bcr_pkg::RST_FRAME_WIDTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bcr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_wr    (cfg_wr),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .luma      (luma),
        .frame_end (frame_end),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    bcr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    bcr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_not_empty   (q_not_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .counter_value (counter_value),
        .discontinuity (discontinuity),
        .resumed       (resumed),
        .in_error      (in_error),
        .error_total   (error_total),
        .frames_seen   (frames_seen)
    );

    `BCR_ASSERT_SAME(a_flags_exclusive, out_valid, !(discontinuity && resumed), "break and resume together")
    `BCR_ASSERT_SAME(a_break_sets_error, out_valid && discontinuity, in_error && (error_total != '0), "break without error state")
    `BCR_ASSERT_SAME(a_resume_clears_error, out_valid && resumed, !in_error, "resume left error mode set")
    `BCR_ASSERT_NEXT(a_cfg_stalls_input, cfg_valid && cfg_ready, !in_ready, "input taken during register settle")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the burn-in counter reader: frame stimulus, word predictor, result checks.
`timescale 1ns / 1ps

module tb_top;
    import bcr_pkg::*;

    localparam int RUN_LIMIT = 1000000;
    localparam int SETTLE    = 8;

    typedef struct {
        logic [COUNTER_BITS-1:0] word;
        bit                      disc;
        bit                      resumed;
        bit                      in_err;
        logic [31:0]             errs;
        logic [31:0]             frames;
    } frame_result_t;

    // Decodes the burnt-in word of each frame and tracks the continuity state.
    class counter_tracker;
        logic [START_BITS-1:0]   start_line;
        logic [CELL_BITS-1:0]    bit_width;
        logic [CELL_BITS-1:0]    bit_height;
        logic [FWIDTH_BITS-1:0]  frame_width;
        logic [INDEX_BITS-1:0]   pixel_idx;
        int unsigned             bits_taken;
        logic [COUNTER_BITS-1:0] shift_word;
        logic [COUNTER_BITS-1:0] prev_word;
        logic [31:0]             err_count;
        logic [31:0]             frame_count;
        bit                      err_mode;
        frame_result_t           pending_q[$];
        int                      results_seen;
        int                      errors;

        function new();
            start_line   = RST_START_LINE;
            bit_width    = RST_BIT_WIDTH;
            bit_height   = RST_BIT_HEIGHT;
            frame_width  = RST_FRAME_WIDTH;
            pixel_idx    = '0;
            bits_taken   = 0;
            shift_word   = '0;
            prev_word    = '0;
            err_count    = '0;
            frame_count  = '0;
            err_mode     = 1'b1;
            results_seen = 0;
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_START_LINE:  start_line  = data[START_BITS-1:0];
                REG_BIT_WIDTH:   bit_width   = data[CELL_BITS-1:0];
                REG_BIT_HEIGHT:  bit_height  = data[CELL_BITS-1:0];
                REG_FRAME_WIDTH: frame_width = data[FWIDTH_BITS-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned row_base();
            longint unsigned b;
            b = start_line;
            b = b + bit_height / 2;
            b = b * frame_width;
            return b;
        endfunction

        function void note_pixel(logic [LUMA_BITS-1:0] l, bit last);
            longint unsigned base;
            longint unsigned half;
            bit              lit;
            bit              jump;
            logic [COUNTER_BITS-1:0] word;
            frame_result_t   r;
            base = row_base();
            half = bit_width / 2;
            lit  = (l > LUMA_THRESHOLD);
            if (pixel_idx < INDEX_CEILING)
            begin
                while (bits_taken < COUNTER_BITS &&
                       base + (2 * bits_taken + 1) * half == pixel_idx)
                begin
                    shift_word = {shift_word[COUNTER_BITS-2:0], lit};
                    bits_taken++;
                end
            end
            if (!last)
            begin
                if (pixel_idx < INDEX_CEILING)
                    pixel_idx++;
                return;
            end
            // bits never sampled stay zero at the bottom of the word
            word = shift_word << (COUNTER_BITS - bits_taken);
            frame_count++;
            jump = (prev_word != '0) && ({1'b0, prev_word} + 33'd1 != {1'b0, word});
            r.word    = word;
            r.disc    = jump;
            r.resumed = !jump && err_mode;
            if (jump)
            begin
                if (err_count != WORD_ONES)
                    err_count++;
                err_mode = 1'b1;
            end
            else
                err_mode = 1'b0;
            r.in_err   = err_mode;
            r.errs     = err_count;
            r.frames   = frame_count;
            prev_word  = word;
            pixel_idx  = '0;
            bits_taken = 0;
            shift_word = '0;
            pending_q.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("ERROR: result %0d %s: got %h, expected %h", results_seen, what, got, want);
            errors++;
        endtask

        task check_result(logic [COUNTER_BITS-1:0] cv, bit dis, bit res, bit ie,
                          logic [31:0] et, logic [31:0] fs);
            frame_result_t w;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                report_mismatch("arrived with no frame pending", cv, '0);
                return;
            end
            w = pending_q.pop_front();
            if (cv !== w.word)    report_mismatch("counter_value", cv, w.word);
            if (dis !== w.disc)   report_mismatch("discontinuity", 32'(dis), 32'(w.disc));
            if (res !== w.resumed) report_mismatch("resumed", 32'(res), 32'(w.resumed));
            if (ie !== w.in_err)  report_mismatch("in_error", 32'(ie), 32'(w.in_err));
            if (et !== w.errs)    report_mismatch("error_total", et, w.errs);
            if (fs !== w.frames)  report_mismatch("frames_seen", fs, w.frames);
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [LUMA_BITS-1:0]      luma      = '0;
    logic                      frame_end = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [COUNTER_BITS-1:0]   counter_value;
    logic                      discontinuity;
    logic                      resumed;
    logic                      in_error;
    logic [31:0]               error_total;
    logic [31:0]               frames_seen;

    counter_tracker          tracker = new();
    int                      cycles = 0;
    int unsigned             items = 0;
    int unsigned             frames_sent = 0;
    int unsigned             send_idle_pct = 0;
    int unsigned             stall_pct = 0;
    logic [COUNTER_BITS-1:0] next_word = '0;

    burnin_counter_reader dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .luma          (luma),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .counter_value (counter_value),
        .discontinuity (discontinuity),
        .resumed       (resumed),
        .in_error      (in_error),
        .error_total   (error_total),
        .frames_seen   (frames_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("ERROR: run limit of %0d cycles reached", RUN_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // handshake values are stable mid-cycle; the request lands at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(counter_value, discontinuity, resumed, in_error,
                                 error_total, frames_seen);
    end

    task cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data, bit hold);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            if (took)
                tracker.set_reg(idx, data);
            @(posedge clk);
        end
        while (!took);
        if (!hold)
            cfg_valid <= 1'b0;
    endtask

    task program_regs(logic [CFG_DATA_BITS-1:0] sl, logic [CFG_DATA_BITS-1:0] bw,
                      logic [CFG_DATA_BITS-1:0] bh, logic [CFG_DATA_BITS-1:0] fw);
        cfg_write(REG_START_LINE, sl, 1'b1);
        cfg_write(REG_BIT_WIDTH, bw, 1'b1);
        cfg_write(REG_BIT_HEIGHT, bh, 1'b1);
        cfg_write(REG_FRAME_WIDTH, fw, 1'b0);
    endtask

    task send_pixel(logic [LUMA_BITS-1:0] l, bit last);
        bit took;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        luma      <= l;
        frame_end <= last;
        do
        begin
            @(negedge clk);
            took = in_ready;
            if (took)
                tracker.note_pixel(l, last);
            @(posedge clk);
        end
        while (!took);
        items++;
    endtask

    task wait_results_drained();
        in_valid <= 1'b0;
        while (tracker.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Burns the word into the sample row as seen through the current registers.
    task send_frame(logic [COUNTER_BITS-1:0] word, int unsigned len, int unsigned change_at);
        int unsigned     i;
        longint unsigned base;
        longint unsigned half;
        longint unsigned off;
        longint unsigned k;
        bit              sampled;
        bit              b;
        logic [LUMA_BITS-1:0] l;
        for (i = 0; i < len; i++)
        begin
            if (change_at != 0 && i == change_at)
            begin
                wait_results_drained();
                cfg_write(REG_BIT_WIDTH, CFG_DATA_BITS'($urandom_range(0, 5)), 1'b0);
            end
            base    = tracker.row_base();
            half    = tracker.bit_width / 2;
            sampled = 1'b0;
            b       = 1'b0;
            if (i >= base)
            begin
                off = i - base;
                if (half == 0)
                begin
                    sampled = (off == 0);
                    b       = word[COUNTER_BITS-1];
                end
                else if (off >= half && (off - half) % (2 * half) == 0)
                begin
                    k = (off - half) / (2 * half);
                    if (k < COUNTER_BITS)
                    begin
                        sampled = 1'b1;
                        b       = word[COUNTER_BITS-1-k];
                    end
                end
            end
            if (!sampled)
                l = LUMA_BITS'($urandom_range(0, 255));
            else if (b)
                l = LUMA_BITS'($urandom_range(8'h81, 8'hFF));
            else
                l = LUMA_BITS'($urandom_range(8'h00, 8'h80));
            send_pixel(l, i == len - 1);
        end
        frames_sent++;
    endtask

    task run_frames(int unsigned count, bit mid_change);
        int unsigned     n;
        int unsigned     sel;
        int unsigned     full;
        int unsigned     len;
        longint unsigned half;
        logic [COUNTER_BITS-1:0] word;
        for (n = 0; n < count; n++)
        begin
            half = tracker.bit_width / 2;
            full = 32'(tracker.row_base() + 63 * half + 1);
            // mostly complete frames; some cut short before the last cell
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(1, full);
            else
                len = full + $urandom_range(0, 6);
            sel = $urandom_range(0, 19);
            if (sel < 2)
                word = $urandom;
            else if (sel == 2)
                word = WORD_ONES;
            else if (sel == 3)
                word = '0;
            else
                word = next_word;
            next_word = word + 1'b1;
            send_frame(word, len, (mid_change && n == 0) ? len / 2 : 0);
        end
    endtask

    task set_idling(int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 45; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 45; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
        endcase
    endtask

    initial
    begin
        int unsigned phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(0);

        // half-cell of zero: every bit reads pixel 1 of a one-pixel-wide raster
        program_regs(1, 0, 1, 1);
        send_pixel(8'hFF, 1'b1);              // short frame, nothing sampled
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h81, 1'b1);              // all ones
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h80, 1'b1);              // wraps to zero: flagged
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b1);              // previous zero, resumes
        send_pixel(8'h5A, 1'b0);
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'h13, 1'b0);
        send_pixel(8'h7F, 1'b1);
        send_pixel(8'h80, 1'b1);
        frames_sent += 7;
        wait_results_drained();

        phase = 1;
        while (phase <= 8 || items < 1600)
        begin
            set_idling(phase % 4);
            case (phase)
                3:
                begin
                    // half-cell of one: a sample on every other pixel of the row
                    program_regs(1, 2, 0, 1);
                    run_frames(3, 1'b0);
                end
                5:
                begin
                    // zero half-cell below an offset sample row
                    program_regs(3, 1, 4, 7);
                    run_frames(3, 1'b0);
                end
                7:
                begin
                    // upper data bits beyond each register are dropped
                    program_regs(13'h1801, 13'h1F02, 13'h1F02, 2);
                    run_frames(1, 1'b0);
                end
                default:
                begin
                    program_regs(CFG_DATA_BITS'($urandom_range(1, 3)),
                                 CFG_DATA_BITS'($urandom_range(0, 3)),
                                 CFG_DATA_BITS'($urandom_range(0, 4)),
                                 CFG_DATA_BITS'($urandom_range(1, 6)));
                    run_frames(4, phase % 4 == 2);
                end
            endcase
            wait_results_drained();
            phase++;
        end

        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
